@@ rtl/tae_pkg.sv @@
package tae_pkg;

    // Width of the CORDIC x/y datapath (covers guard bits and the CORDIC gain)
    localparam int XW = 46;
    // Width of the CORDIC angle accumulator (32-bit binary angle plus headroom)
    localparam int ZW = 34;
    // Guard bits added below the 28.4 position format
    localparam int GUARD_BITS = 8;
    // CORDIC gain in Q30
    localparam logic [30:0] GAIN_Q30 = 31'd1768195364;
    // Quarter turn in 32-bit binary angle units
    localparam logic signed [ZW-1:0] ANG_90 = 34'sd1073741824;
    // Elevation limits in 16-bit binary angle units
    localparam logic signed [15:0] EL_MAX = 16'sd16384;
    localparam logic signed [15:0] EL_MIN = -16'sd16384;

    // atan(2^-i) in 32-bit binary angle units, rounded to nearest
    function automatic logic [31:0] atan_angle(input int i);
        logic [31:0] a;
        case (i)
            0:  a = 32'd536870912;
            1:  a = 32'd316933406;
            2:  a = 32'd167458907;
            3:  a = 32'd85004756;
            4:  a = 32'd42667331;
            5:  a = 32'd21354465;
            6:  a = 32'd10679838;
            7:  a = 32'd5340245;
            8:  a = 32'd2670163;
            9:  a = 32'd1335087;
            10: a = 32'd667544;
            11: a = 32'd333772;
            12: a = 32'd166886;
            13: a = 32'd83443;
            14: a = 32'd41722;
            15: a = 32'd20861;
            16: a = 32'd10430;
            17: a = 32'd5215;
            18: a = 32'd2608;
            19: a = 32'd1304;
            20: a = 32'd652;
            21: a = 32'd326;
            22: a = 32'd163;
            23: a = 32'd81;
            24: a = 32'd41;
            25: a = 32'd20;
            26: a = 32'd10;
            27: a = 32'd5;
            28: a = 32'd3;
            29: a = 32'd1;
            30: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/target_azimuth_elevation_core.sv @@
// Target azimuth and elevation pipeline.
// Input channel: in_valid / in_stall with own position, own heading and
// target position (28.4 feet, heading as 16-bit binary angle). Output
// channel: out_valid / out_stall with azimuth and elevation as 16-bit
// binary angles (32768 = pi); elevation stays within +/-16384.
// A transaction is taken on a clock edge with valid high and stall low.
// Throughput: one transaction per cycle while out_stall does not hold the
// pipeline. The path runs through the difference stage, the scaling and
// gain-multiply stage, two vectoring CORDIC pipelines of CORDIC_STAGES + 1
// registers each, and the output register.
// The whole pipeline advances together; it holds while a finished result
// sits in the output register and out_stall is high, and in_stall follows
// that condition in the same cycle. Empty slots move forward, so the block
// keeps taking input while the output register is empty.
// Reset clears all valid bits; no result is presented until new input
// arrives. Payload registers are not reset.
module target_azimuth_elevation_core #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] own_x,
    input  logic signed [31:0] own_y,
    input  logic signed [31:0] own_z,
    input  logic [15:0]        own_heading,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] azimuth,
    output logic signed [15:0] elevation
);

    localparam int XW = tae_pkg::XW;
    localparam int ZW = tae_pkg::ZW;
    localparam int S1W = 16 + 3 + XW;
    localparam int S2W = 16 + 3;

    logic en;

    // Difference stage
    logic               d_valid_reg;
    logic signed [32:0] dx_reg;
    logic signed [32:0] dy_reg;
    logic signed [32:0] dz_reg;
    logic [15:0]        hd_reg;

    // Scale and gain-multiply stage
    logic               m_valid_reg;
    logic signed [XW-1:0] hx_reg;
    logic signed [XW-1:0] hy_reg;
    logic signed [65:0] prod_reg;
    logic [15:0]        m_hd_reg;
    logic               m_zero_reg;
    logic               m_neg_reg;
    logic               m_pos_reg;

    logic signed [33:0] ndz;
    logic signed [65:0] prod_next;

    // Output stage
    logic               o_valid_reg;
    logic signed [15:0] az_reg;
    logic signed [15:0] el_reg;
    logic signed [15:0] az_next;
    logic signed [15:0] el_next;

    logic                 c1_valid;
    logic signed [XW-1:0] c1_x;
    logic signed [ZW-1:0] c1_z;
    logic [S1W-1:0]       c1_side;
    logic signed [XW-1:0] vy;

    logic                 c2_valid;
    logic signed [XW-1:0] c2_x;
    logic signed [ZW-1:0] c2_z;
    logic [S2W-1:0]       c2_side;

    logic [31:0]          az_full;
    logic [15:0]          az1;
    logic signed [ZW-1:0] el_round;
    logic signed [17:0]   el_wide;

    // Advance the whole pipeline unless a held result blocks it
    assign en       = !o_valid_reg || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= in_valid;
            m_valid_reg <= d_valid_reg;
            o_valid_reg <= c2_valid;
        end
    end

    // Form exact 33-bit differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= {target_x[31], target_x} - {own_x[31], own_x};
            dy_reg <= {target_y[31], target_y} - {own_y[31], own_y};
            dz_reg <= {target_z[31], target_z} - {own_z[31], own_z};
            hd_reg <= own_heading;
        end
    end

    // Scale up by the guard bits and apply the CORDIC gain to the vertical part
    assign ndz       = -{dz_reg[32], dz_reg};
    assign prod_next = 66'(ndz) * 66'($signed({1'b0, tae_pkg::GAIN_Q30}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hx_reg     <= {{(XW - 33 - tae_pkg::GUARD_BITS){dx_reg[32]}}, dx_reg,
                           {tae_pkg::GUARD_BITS{1'b0}}};
            hy_reg     <= {{(XW - 33 - tae_pkg::GUARD_BITS){dy_reg[32]}}, dy_reg,
                           {tae_pkg::GUARD_BITS{1'b0}}};
            prod_reg   <= prod_next;
            m_hd_reg   <= hd_reg;
            m_zero_reg <= (dx_reg == '0) && (dy_reg == '0);
            m_neg_reg  <= dz_reg < 0;
            m_pos_reg  <= dz_reg > 0;
        end
    end

    // Floor shift of the gain product back to the guarded scale
    assign vy = XW'(prod_reg >>> (30 - tae_pkg::GUARD_BITS));

    tae_cordic_vec #(
        .STAGES (CORDIC_STAGES),
        .SW     (S1W)
    ) u_cordic_az (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid_reg),
        .in_x      (hx_reg),
        .in_y      (hy_reg),
        .in_side   ({m_hd_reg, m_zero_reg, m_neg_reg, m_pos_reg, vy}),
        .out_valid (c1_valid),
        .out_x     (c1_x),
        .out_z     (c1_z),
        .out_side  (c1_side)
    );

    // Subtract heading and round the bearing to 16 bits
    assign az_full = c1_z[31:0] - {c1_side[S1W-1 -: 16], 16'h0000} + 32'h0000_8000;
    assign az1     = az_full[31:16];

    tae_cordic_vec #(
        .STAGES (CORDIC_STAGES),
        .SW     (S2W)
    ) u_cordic_el (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c1_valid),
        .in_x      (c1_x),
        .in_y      (c1_side[XW-1:0]),
        .in_side   ({az1, c1_side[XW+2], c1_side[XW+1], c1_side[XW]}),
        .out_valid (c2_valid),
        .out_x     (c2_x),
        .out_z     (c2_z),
        .out_side  (c2_side)
    );

    // Round and clamp the elevation; handle a zero horizontal distance
    assign el_round = (c2_z + ZW'(32'h0000_8000)) >>> 16;
    assign el_wide  = el_round[17:0];

    always_comb
    begin
        if (c2_side[2])
        begin
            az_next = '0;
            if (c2_side[1])
            begin
                el_next = tae_pkg::EL_MAX;
            end
            else if (c2_side[0])
            begin
                el_next = tae_pkg::EL_MIN;
            end
            else
            begin
                el_next = '0;
            end
        end
        else
        begin
            az_next = c2_side[S2W-1 -: 16];
            if (el_wide > 18'(tae_pkg::EL_MAX))
            begin
                el_next = tae_pkg::EL_MAX;
            end
            else if (el_wide < 18'(tae_pkg::EL_MIN))
            begin
                el_next = tae_pkg::EL_MIN;
            end
            else
            begin
                el_next = el_wide[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            az_reg <= az_next;
            el_reg <= el_next;
        end
    end

    // The final horizontal magnitude on c2_x is not needed downstream
    assign out_valid = o_valid_reg;
    assign azimuth   = az_reg;
    assign elevation = el_reg;

endmodule

@@ rtl/tae_cordic_vec.sv @@
module tae_cordic_vec #(
    parameter int STAGES = 16,
    parameter int SW = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [tae_pkg::XW-1:0]  in_x,
    input  logic signed [tae_pkg::XW-1:0]  in_y,
    input  logic [SW-1:0]                  in_side,
    output logic                           out_valid,
    output logic signed [tae_pkg::XW-1:0]  out_x,
    output logic signed [tae_pkg::ZW-1:0]  out_z,
    output logic [SW-1:0]                  out_side
);

    logic signed [tae_pkg::XW-1:0] x_reg [0:STAGES];
    logic signed [tae_pkg::XW-1:0] y_reg [0:STAGES];
    logic signed [tae_pkg::ZW-1:0] z_reg [0:STAGES];
    logic [SW-1:0]                 side_reg [0:STAGES];
    logic                          valid_reg [0:STAGES];

    logic signed [tae_pkg::XW-1:0] x0_next;
    logic signed [tae_pkg::XW-1:0] y0_next;
    logic signed [tae_pkg::ZW-1:0] z0_next;

    // Pre-rotate by a quarter turn into the right half plane
    always_comb
    begin
        x0_next = in_x;
        y0_next = in_y;
        z0_next = '0;
        if (in_x < 0)
        begin
            if (in_y >= 0)
            begin
                x0_next = in_y;
                y0_next = -in_x;
                z0_next = tae_pkg::ANG_90;
            end
            else
            begin
                x0_next = -in_y;
                y0_next = in_x;
                z0_next = -tae_pkg::ANG_90;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            side_reg[0] <= in_side;
        end
    end

    // One micro-rotation per stage
    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        logic signed [tae_pkg::XW-1:0] x_next;
        logic signed [tae_pkg::XW-1:0] y_next;
        logic signed [tae_pkg::ZW-1:0] z_next;
        logic signed [tae_pkg::ZW-1:0] ang;

        assign ang = tae_pkg::ZW'(tae_pkg::atan_angle(k));

        always_comb
        begin
            if (y_reg[k] >= 0)
            begin
                x_next = x_reg[k] + (y_reg[k] >>> k);
                y_next = y_reg[k] - (x_reg[k] >>> k);
                z_next = z_reg[k] + ang;
            end
            else
            begin
                x_next = x_reg[k] - (y_reg[k] >>> k);
                y_next = y_reg[k] + (x_reg[k] >>> k);
                z_next = z_reg[k] - ang;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1]    <= x_next;
                y_reg[k+1]    <= y_next;
                z_reg[k+1]    <= z_next;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_x     = x_reg[STAGES];
    assign out_z     = z_reg[STAGES];
    assign out_side  = side_reg[STAGES];

endmodule

@@ rtl/tae_checker.sv @@
module tae_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] azimuth,
    input logic signed [15:0] elevation
);

    // A held result stays presented
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A held result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(azimuth) && $stable(elevation))
        else $error("result changed while stalled");

    // Input is only blocked by a stalled result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

    // Elevation stays within a quarter turn
    a_el_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (elevation <= 16'sd16384) && (elevation >= -16'sd16384))
        else $error("elevation out of range");

    // Nothing comes out right after reset without input
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result after reset");

endmodule

bind target_azimuth_elevation_core tae_checker u_tae_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .azimuth   (azimuth),
    .elevation (elevation)
);
